[design/assert_macros.svh]
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property, disabled while reset is asserted.
`define ASSERT_CLK(lbl, clk_s, rst_n_s, prop, msg) \
	lbl: assert property (@(posedge clk_s) disable iff (!rst_n_s) prop) else $error(msg);

// Clocked property that is also checked during reset.
`define ASSERT_ALWAYS(lbl, clk_s, prop, msg) \
	lbl: assert property (@(posedge clk_s) prop) else $error(msg);

`endif

[design/hcbd_pkg.sv]
package hcbd_pkg;

	// Width of lengths, counts and the size limit
	localparam int LEN_W = 24;

	localparam logic [LEN_W-1:0] LIMIT_RESET = LEN_W'(1048576);

	localparam logic [7:0] CHAR_CR    = 8'h0D;
	localparam logic [7:0] CHAR_LF    = 8'h0A;
	localparam logic [7:0] CHAR_SPACE = 8'h20;
	localparam logic [7:0] CHAR_TAB   = 8'h09;

	// Bytes skipped after each chunk's payload
	localparam logic [1:0] SKIP_BYTES = 2'd2;

	typedef enum logic [4:0] {
		PH_LEAD    = 5'b00001,
		PH_DIGITS  = 5'b00010,
		PH_REST    = 5'b00100,
		PH_PAYLOAD = 5'b01000,
		PH_SKIP    = 5'b10000
	} phase_t;

	typedef enum logic [1:0] {
		ST_OK         = 2'd0,
		ST_INCOMPLETE = 2'd1,
		ST_TOO_LARGE  = 2'd2
	} status_t;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       last_byte;
	} in_item_t;

	typedef struct packed {
		logic [7:0]       body_byte;
		logic             payload_valid;
		logic             done_res;
		logic [1:0]       status;
		logic [LEN_W-1:0] total_length;
	} out_item_t;

	typedef struct packed {
		phase_t           phase;
		logic             saw_cr;
		logic [LEN_W:0]   acc;
		logic [LEN_W-1:0] left;
		logic [1:0]       skip;
		logic [LEN_W-1:0] total;
		logic             finished;
	} dec_state_t;

	localparam dec_state_t STATE_CLEAR = '{
		phase:    PH_LEAD,
		saw_cr:   1'b0,
		acc:      '0,
		left:     '0,
		skip:     '0,
		total:    '0,
		finished: 1'b0
	};

	// Hex digit decode: {is_hex, value}
	function automatic logic [4:0] hex_decode(input logic [7:0] c);
		logic [4:0] r;
		r = '0;
		if (c inside {[8'h30:8'h39]}) begin
			r = {1'b1, 4'(c - 8'h30)};
		end else if (c inside {[8'h61:8'h66]}) begin
			r = {1'b1, 4'(c - 8'h57)};
		end else if (c inside {[8'h41:8'h46]}) begin
			r = {1'b1, 4'(c - 8'h37)};
		end
		return r;
	endfunction

endpackage

[design/hcbd_step.sv]
module hcbd_step
	import hcbd_pkg::*;
(
	input  dec_state_t       st,
	input  in_item_t         item,
	input  logic [LEN_W-1:0] limit,
	output dec_state_t       nxt,
	output out_item_t        res
);

	// Next state and result for one byte
	always_comb begin
		logic [4:0]       hx;
		logic [LEN_W-1:0] left_dec;
		logic [1:0]       skip_dec;
		logic [LEN_W:0]   sz;
		logic [LEN_W+1:0] sum;
		logic             done;
		status_t          stat;

		hx       = hex_decode(item.data_byte);
		left_dec = (st.left != '0) ? st.left - 1'b1 : st.left;
		skip_dec = (st.skip != '0) ? st.skip - 1'b1 : st.skip;
		sz       = st.acc;
		sum      = {2'b00, st.total} + {1'b0, sz};
		done     = 1'b0;
		stat     = ST_OK;
		nxt      = st;
		res      = '0;

		if (!st.finished) begin
			case (st.phase)
				PH_PAYLOAD: begin
					res.body_byte     = item.data_byte;
					res.payload_valid = 1'b1;
					nxt.total         = st.total + 1'b1;
					nxt.left          = left_dec;
					if (left_dec == '0) begin
						nxt.phase = PH_SKIP;
						nxt.skip  = SKIP_BYTES;
					end
					if (item.last_byte) begin
						done = 1'b1;
						stat = ST_INCOMPLETE;
					end
				end
				PH_SKIP: begin
					nxt.skip = skip_dec;
					if (skip_dec == '0) begin
						nxt.phase  = PH_LEAD;
						nxt.saw_cr = 1'b0;
						nxt.acc    = '0;
						if (item.last_byte) begin
							done = 1'b1;
							stat = ST_OK;
						end
					end else if (item.last_byte) begin
						done = 1'b1;
						stat = ST_INCOMPLETE;
					end
				end
				PH_LEAD, PH_DIGITS, PH_REST: begin
					if (item.data_byte == CHAR_LF && st.saw_cr) begin
						// End of size line
						nxt.saw_cr = 1'b0;
						nxt.acc    = '0;
						if (sz == '0) begin
							done = 1'b1;
							stat = ST_OK;
						end else if (sum > {2'b00, limit}) begin
							done = 1'b1;
							stat = ST_TOO_LARGE;
						end else begin
							nxt.phase = PH_PAYLOAD;
							nxt.left  = sz[LEN_W-1:0];
							if (item.last_byte) begin
								done = 1'b1;
								stat = ST_INCOMPLETE;
							end
						end
					end else begin
						nxt.saw_cr = (item.data_byte == CHAR_CR);
						if (st.phase == PH_LEAD) begin
							if (hx[4]) begin
								nxt.acc   = {{(LEN_W-3){1'b0}}, hx[3:0]};
								nxt.phase = PH_DIGITS;
							end else if (item.data_byte != CHAR_SPACE &&
								item.data_byte != CHAR_TAB) begin
								nxt.phase = PH_REST;
							end
						end else if (st.phase == PH_DIGITS) begin
							if (hx[4]) begin
								// Saturating acc * 16 + digit
								if (|st.acc[LEN_W:LEN_W-3]) begin
									nxt.acc = '1;
								end else begin
									nxt.acc = {st.acc[LEN_W-4:0], hx[3:0]};
								end
							end else begin
								nxt.phase = PH_REST;
							end
						end
						if (item.last_byte) begin
							done = 1'b1;
							stat = ST_INCOMPLETE;
						end
					end
				end
				default: ;
			endcase
			if (done) begin
				nxt.finished = 1'b1;
			end
		end

		res.done_res     = done;
		res.status       = stat;
		res.total_length = nxt.total;

		// Last byte of a message starts the next one fresh
		if (item.last_byte) begin
			nxt = STATE_CLEAR;
		end
	end

endmodule

[design/http_chunked_body_decoder_unit.sv]
// Chunked HTTP body decoder. Takes one raw byte per clock cycle and returns exactly
// one result item per byte, in the cycle after the byte is accepted, from an output
// register. The decode state and that output register are the only stages, so a
// byte is taken every cycle unless a result waits untaken in the output register,
// in which case in_ready follows out_ready. The size limit is written through the
// cfg channel, which is always ready; write it only between messages.
module http_chunked_body_decoder_unit
	import hcbd_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  in_item_t         in_data,
	output logic             out_valid,
	input  logic             out_ready,
	output out_item_t        out_data,
	input  logic             cfg_valid,
	output logic             cfg_ready,
	input  logic [LEN_W-1:0] cfg_data
);

	dec_state_t       state_q;
	dec_state_t       state_nxt;
	out_item_t        res;
	out_item_t        out_data_q;
	logic             out_valid_q;
	logic [LEN_W-1:0] limit_q;
	logic             in_fire;

	assign in_ready  = !out_valid_q || out_ready;
	assign in_fire   = in_valid && in_ready;
	assign cfg_ready = 1'b1;
	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

	hcbd_step u_step (
		.st    (state_q),
		.item  (in_data),
		.limit (limit_q),
		.nxt   (state_nxt),
		.res   (res)
	);

	// Size limit register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q <= LIMIT_RESET;
		end else if (cfg_valid) begin
			limit_q <= cfg_data;
		end
	end

	// Decode state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= STATE_CLEAR;
		end else if (in_fire) begin
			state_q <= state_nxt;
		end
	end

	// Output register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (in_fire) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Output register payload
	always_ff @(posedge clk) begin
		if (in_fire) begin
			out_data_q <= res;
		end
	end

endmodule

[design/hcbd_checker.sv]
`include "assert_macros.svh"

module hcbd_checker
	import hcbd_pkg::*;
(
	input logic             clk,
	input logic             arst_n,
	input logic             in_valid,
	input logic             in_ready,
	input logic             out_valid,
	input logic             out_ready,
	input out_item_t        out_data
);

	logic out_stall;
	logic quiet_ok;

	assign out_stall = out_valid && !out_ready;
	assign quiet_ok  = (out_data.status == ST_OK) &&
		(out_data.payload_valid || out_data.body_byte == 8'd0);

	// An accepted byte always produces an item in the next cycle
	`ASSERT_CLK(a_item_follows, clk, arst_n, in_valid && in_ready |=> out_valid, "no item after byte")

	// Input is never blocked while the output register is empty
	`ASSERT_ALWAYS(a_ready_when_empty, clk, !out_valid |-> in_ready, "input stalled while empty")

	// A stalled item holds
	`ASSERT_CLK(a_out_hold, clk, arst_n, out_stall |=> out_valid && $stable(out_data), "item changed")

	// Status only comes with done, and body_byte is zero unless it carries payload
	`ASSERT_CLK(a_status_done, clk, arst_n, out_valid && !out_data.done_res |-> quiet_ok, "stray status")

endmodule

bind http_chunked_body_decoder_unit hcbd_checker u_hcbd_checker (.*);
